>>> hdl/keyframe_position_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// Keyframe position interpolator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSITION_INTERPOLATOR_CORE_ASSERT_SVH
`define KEYFRAME_POSITION_INTERPOLATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/kpi_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe position interpolator package
// Word types of the item and result channels, keyframe entry and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package kpi_pkg;

  localparam int TIME_W  = 32;
  localparam int COORD_W = 32;
  localparam int SLOT_W  = 6;
  localparam int SEG_W   = 6;
  localparam int CFG_W   = 7;
  localparam int FRAC_W  = 16;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic [TIME_W-1:0]         sample_time;
    logic [SLOT_W-1:0]         key_index;
    logic [TIME_W-1:0]         key_time;
    logic signed [COORD_W-1:0] key_x;
    logic signed [COORD_W-1:0] key_y;
    logic signed [COORD_W-1:0] key_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      moved;
    logic                      advanced;
    logic                      finished;
    logic [SEG_W-1:0]          segment_now;
  } out_word_t;

  // One keyframe as it is held in the table memory.
  typedef struct packed {
    logic [TIME_W-1:0]         key_time;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

endpackage

`default_nettype wire

>>> hdl/kpi_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kpi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> hdl/keyframe_position_interpolator_core.sv
// ----------------------------------------------------------------------------
// Keyframe position interpolator core
// Keyframe table in RAM, linear interpolation of the current x,y,z position.
// ----------------------------------------------------------------------------
// The block takes one word at a time and returns exactly one result word for
// each. A keyframe write or a finished tick goes straight to the output
// register; other ticks read both keyframes, then one that advances emits, one
// at or before the segment start runs subtract, multiply and add per coordinate
// and one inside the segment runs the divider first. The longest case is set by
// the two reads through the single read port of the keyframe RAM, the 16-step
// restoring divider that forms the Q0.16 fraction, and one shared multiplier
// that serves the three coordinates in turn. A further item is accepted in the
// cycle after the result is placed in the output register, even if that result
// is still stalled. The frame count register may be written at any time the
// core is idle; the keyframe table needs no clearing after reset.
`default_nettype none

`include "keyframe_position_interpolator_core_assert.svh"

module keyframe_position_interpolator_core #(
  parameter int MAX_FRAMES = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire kpi_pkg::in_word_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output kpi_pkg::out_word_t             out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [kpi_pkg::CFG_W-1:0] cfg_data
);

  import kpi_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAMES);
  localparam int CMP_W = (IDX_W + 2 > CFG_W + 1) ? IDX_W + 2 : CFG_W + 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_FRAMES);
  localparam int PROD_W = COORD_W + 1 + FRAC_W + 1;
  localparam int SUM_W  = COORD_W + 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_SUB  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  localparam logic [1:0] LAST_K = 2'd2;

  // Control state
  logic [3:0]                state_r, state_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic signed [COORD_W-1:0] pos_r [3];
  logic signed [COORD_W-1:0] pos_nxt [3];
  logic [CFG_W-1:0]          fc_r, fc_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                k_r, k_nxt;

  // Working registers
  key_entry_t                a_r, a_nxt;
  key_entry_t                b_r, b_nxt;
  logic [TIME_W-1:0]         t_r, t_nxt;
  logic [TIME_W-1:0]         rem_r, rem_nxt;
  logic [TIME_W-1:0]         den_r, den_nxt;
  logic [FRAC_W-1:0]         frac_r, frac_nxt;
  logic [$clog2(FRAC_W)-1:0] div_cnt_r, div_cnt_nxt;
  logic signed [COORD_W:0]   diff_r, diff_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic                      moved_r, moved_nxt;
  logic                      adv_r, adv_nxt;
  logic                      fin_r, fin_nxt;
  out_word_t                 out_data_r, out_data_nxt;

  // Table memory ports
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_wr_addr;
  key_entry_t                ram_wr_data;
  logic [IDX_W-1:0]          ram_rd_addr;
  logic [ENTRY_W-1:0]        ram_rd_data;

  // Combinational helpers
  logic                      in_acc;
  logic [CMP_W-1:0]          fc_ext;
  logic [CMP_W-1:0]          cnt_eff;
  logic                      fin_c;
  logic [TIME_W:0]           rem_shift;
  logic                      q_bit;
  logic signed [COORD_W-1:0] a_coord, b_coord;
  logic signed [FRAC_W:0]    frac_s;
  logic signed [SUM_W-1:0]   sum_c;
  logic signed [COORD_W-1:0] sat_c;

  kpi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FRAMES)
  ) u_key_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_we      = in_acc && (in_data.operation == OP_WRITE) &&
                       (CMP_W'(in_data.key_index) < MAX_C);
  assign ram_wr_addr = IDX_W'(in_data.key_index);
  assign ram_wr_data = '{key_time: in_data.key_time, x: in_data.key_x,
                         y: in_data.key_y, z: in_data.key_z};
  // The start keyframe is read at acceptance, the end keyframe in the cycle after.
  assign ram_rd_addr = (state_r == S_RDA) ? IDX_W'(idx_r + 1'b1) : idx_r;

  // A count above the table size is treated as the table size.
  assign fc_ext  = CMP_W'(fc_r);
  assign cnt_eff = (fc_ext > MAX_C) ? MAX_C : fc_ext;
  assign fin_c   = (cnt_eff < CMP_W'(2)) || ((CMP_W'(idx_r) + 1'b1) >= cnt_eff);

  // Restoring division step; the remainder always stays below the divisor.
  assign rem_shift = {rem_r, 1'b0};
  assign q_bit     = (rem_shift >= {1'b0, den_r});

  always_comb begin
    case (k_r)
      2'd0:    begin a_coord = a_r.x; b_coord = b_r.x; end
      2'd1:    begin a_coord = a_r.y; b_coord = b_r.y; end
      default: begin a_coord = a_r.z; b_coord = b_r.z; end
    endcase
  end

  assign frac_s = $signed({1'b0, frac_r});
  // The arithmetic shift of the product gives the floor of the scaled step.
  assign sum_c  = $signed({{3{a_coord[COORD_W-1]}}, a_coord}) +
                  $signed({prod_r[PROD_W-1], prod_r[PROD_W-1:FRAC_W]});

  always_comb begin
    if (sum_c[SUM_W-1:COORD_W-1] == '0 || sum_c[SUM_W-1:COORD_W-1] == '1) begin
      sat_c = sum_c[COORD_W-1:0];
    end else if (sum_c[SUM_W-1]) begin
      sat_c = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    fc_nxt        = fc_r;
    out_valid_nxt = out_valid_r && out_stall;
    k_nxt         = k_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    frac_nxt      = frac_r;
    div_cnt_nxt   = div_cnt_r;
    diff_nxt      = diff_r;
    prod_nxt      = prod_r;
    moved_nxt     = moved_r;
    adv_nxt       = adv_r;
    fin_nxt       = fin_r;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      fc_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          moved_nxt = 1'b0;
          adv_nxt   = 1'b0;
          fin_nxt   = 1'b0;
          t_nxt     = in_data.sample_time;
          if (in_data.operation == OP_WRITE) begin
            state_nxt = S_EMIT;
          end else if (fin_c) begin
            fin_nxt   = 1'b1;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end
      S_RDA: begin
        a_nxt     = key_entry_t'(ram_rd_data);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        b_nxt     = key_entry_t'(ram_rd_data);
        state_nxt = S_DEC;
      end
      S_DEC: begin
        k_nxt = 2'd0;
        if (b_r.key_time <= a_r.key_time || t_r >= b_r.key_time) begin
          // Equal or reversed times, or the end key reached: step on.
          idx_nxt   = IDX_W'(idx_r + 1'b1);
          adv_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else if (t_r <= a_r.key_time) begin
          frac_nxt  = '0;
          state_nxt = S_SUB;
        end else begin
          rem_nxt     = t_r - a_r.key_time;
          den_nxt     = b_r.key_time - a_r.key_time;
          div_cnt_nxt = '1;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt     = q_bit ? TIME_W'(rem_shift - {1'b0, den_r}) : rem_shift[TIME_W-1:0];
        frac_nxt    = {frac_r[FRAC_W-2:0], q_bit};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == '0) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        diff_nxt  = $signed({b_coord[COORD_W-1], b_coord}) -
                    $signed({a_coord[COORD_W-1], a_coord});
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = diff_r * frac_s;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        pos_nxt[k_r] = sat_c;
        if (k_r == LAST_K) begin
          moved_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SUB;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{pos_x: pos_r[0], pos_y: pos_r[1], pos_z: pos_r[2],
                            moved: moved_r, advanced: adv_r, finished: fin_r,
                            segment_now: SEG_W'(idx_r)};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pos_r       <= '{default: '0};
      fc_r        <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pos_r       <= pos_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    frac_r     <= frac_nxt;
    div_cnt_r  <= div_cnt_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    moved_r    <= moved_nxt;
    adv_r      <= adv_nxt;
    fin_r      <= fin_nxt;
    out_data_r <= out_data_nxt;
  end

  // The table is only written at acceptance, never while a tick reads it.
  `KPI_ASSERT_SAME(a_write_idle, ram_we, state_r == S_IDLE, "table written during a tick")
  // The divider remainder must stay below the divisor throughout.
  `KPI_ASSERT_SAME(a_div_rem, state_r == S_DIV, rem_r < den_r, "divider remainder overflow")
  // The segment index only ever holds or steps by one.
  `KPI_ASSERT_NEXT(a_idx_step, 1'b1,
    idx_r == $past(idx_r) || idx_r == IDX_W'($past(idx_r) + 1'b1), "segment index jumped")
  // At most one of the three outcome flags is reported per result.
  `KPI_ASSERT_SAME(a_flags, out_valid_r,
    $onehot0({out_data_r.moved, out_data_r.advanced, out_data_r.finished}),
    "conflicting outcome flags")

endmodule

`default_nettype wire

>>> tb/keyframe_position_interpolator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe position interpolator core testbench
// Drives keyframe writes and tick words through the core under several frame
// counts and idling patterns, predicts every result word in a scoreboard and
// compares each accepted result field by field.
// ----------------------------------------------------------------------------

module keyframe_position_interpolator_core_tb;

  import kpi_pkg::*;

  localparam int MAX_FRAMES     = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF       = 400;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASES         = 12;
  localparam int PHASE_WORDS    = 78;
  localparam int COUNT_NEAR_END = -1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  class position_scoreboard;
    key_entry_t         key_tab [MAX_FRAMES];
    bit                 written [MAX_FRAMES];
    int unsigned        seg_index;
    logic signed [31:0] pos [3];
    logic [CFG_W-1:0]   frame_count;
    out_word_t          pending_positions [$];
    int                 n_inputs;
    int                 n_writes;
    int                 n_moved;
    int                 n_advanced;
    int                 n_finished;
    int                 n_results;
    int                 mismatches;

    function new();
      seg_index   = 0;
      frame_count = '0;
      for (int k = 0; k < 3; k++) pos[k] = '0;
      for (int k = 0; k < MAX_FRAMES; k++) written[k] = 1'b0;
    endfunction

    function int unsigned eff_count();
      return (frame_count > MAX_FRAMES) ? MAX_FRAMES : frame_count;
    endfunction

    function void set_frame_count(logic [CFG_W-1:0] value);
      frame_count = value;
    endfunction

    function logic signed [31:0] interpolate_coord(logic signed [31:0] a,
                                                   logic signed [31:0] b,
                                                   logic [15:0] frac);
      longint diff;
      longint sum;
      diff = longint'(b) - longint'(a);
      // The arithmetic shift gives the floor of the scaled step.
      sum = longint'(a) + ((diff * longint'({48'd0, frac})) >>> 16);
      if (sum > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (sum < -64'sd2147483648) return 32'sh8000_0000;
      return sum[31:0];
    endfunction

    function void note_input_word(in_word_t w);
      out_word_t   want;
      int unsigned cnt;
      logic [31:0] bt;
      logic [31:0] et;
      logic [63:0] num;
      logic [63:0] quot;
      logic [15:0] frac;
      logic        moved;
      logic        advanced;
      logic        finished;
      moved    = 1'b0;
      advanced = 1'b0;
      finished = 1'b0;
      n_inputs++;
      if (w.operation == OP_WRITE) begin
        key_tab[w.key_index].key_time = w.key_time;
        key_tab[w.key_index].x        = w.key_x;
        key_tab[w.key_index].y        = w.key_y;
        key_tab[w.key_index].z        = w.key_z;
        written[w.key_index]          = 1'b1;
        n_writes++;
      end else begin
        cnt = eff_count();
        if (cnt < 2 || seg_index >= cnt - 1) begin
          finished = 1'b1;
        end else begin
          bt = key_tab[seg_index].key_time;
          et = key_tab[seg_index + 1].key_time;
          if (et <= bt || w.sample_time >= et) begin
            seg_index++;
            advanced = 1'b1;
          end else begin
            frac = '0;
            if (w.sample_time > bt) begin
              num  = {16'h0, w.sample_time - bt, 16'h0};
              quot = num / {32'h0, et - bt};
              frac = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
            end
            pos[0] = interpolate_coord(key_tab[seg_index].x, key_tab[seg_index + 1].x, frac);
            pos[1] = interpolate_coord(key_tab[seg_index].y, key_tab[seg_index + 1].y, frac);
            pos[2] = interpolate_coord(key_tab[seg_index].z, key_tab[seg_index + 1].z, frac);
            moved = 1'b1;
          end
        end
      end
      n_moved    += moved;
      n_advanced += advanced;
      n_finished += finished;
      want.pos_x       = pos[0];
      want.pos_y       = pos[1];
      want.pos_z       = pos[2];
      want.moved       = moved;
      want.advanced    = advanced;
      want.finished    = finished;
      want.segment_now = seg_index[SEG_W-1:0];
      pending_positions.push_back(want);
    endfunction

    function void check_result_word(out_word_t got);
      out_word_t want;
      if (pending_positions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with nothing pending: pos %h %h %h m%b a%b f%b seg %0d",
                   $time, got.pos_x, got.pos_y, got.pos_z, got.moved, got.advanced,
                   got.finished, got.segment_now);
        return;
      end
      want = pending_positions.pop_front();
      n_results++;
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.pos_z !== want.pos_z || got.moved !== want.moved ||
          got.advanced !== want.advanced || got.finished !== want.finished ||
          got.segment_now !== want.segment_now) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result %0d mismatch", $time, n_results);
          $display("  expected pos %h %h %h m%b a%b f%b seg %0d", want.pos_x, want.pos_y,
                   want.pos_z, want.moved, want.advanced, want.finished, want.segment_now);
          $display("  actual   pos %h %h %h m%b a%b f%b seg %0d", got.pos_x, got.pos_y,
                   got.pos_z, got.moved, got.advanced, got.finished, got.segment_now);
        end
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  position_scoreboard sb;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int cfg_writes   = 0;
  int phase_counts [PHASES] = '{64, 64, 127, 64, 0, 64, 1, 100, 64, COUNT_NEAR_END, 127, 64};

  keyframe_position_interpolator_core #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: a long hold-off when one is requested, otherwise random stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_frame_count(cfg_data);
      if (in_valid && !in_stall) sb.note_input_word(in_data);
      if (out_valid && !out_stall) sb.check_result_word(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles, %0d results pending", $time,
                 quiet_cycles, sb.pending_positions.size());
        $display("** keyframe_position_interpolator_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(7, 0))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A time distance in [1, room]; mostly short, sometimes the whole room.
  function automatic logic [31:0] span(logic [31:0] room);
    logic [31:0] lim;
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 4)      lim = (room < 32'd16) ? room : 32'd16;
    else if (r < 8) lim = (room < 32'h4_0000) ? room : 32'h4_0000;
    else            lim = room;
    return $urandom_range(lim, 1);
  endfunction

  function automatic logic [31:0] fresh_end(logic [31:0] bt);
    return (bt == 32'hFFFF_FFFF) ? bt : bt + span(~bt);
  endfunction

  function automatic in_word_t tick_word(logic [31:0] smp);
    in_word_t w;
    w.operation   = OP_TICK;
    w.sample_time = smp;
    w.key_index   = SLOT_W'($urandom);
    w.key_time    = $urandom;
    w.key_x       = $urandom;
    w.key_y       = $urandom;
    w.key_z       = $urandom;
    return w;
  endfunction

  function automatic in_word_t key_word(logic [SLOT_W-1:0] slot, logic [31:0] kt,
                                        logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z);
    in_word_t w;
    w.operation   = OP_WRITE;
    w.sample_time = $urandom;
    w.key_index   = slot;
    w.key_time    = kt;
    w.key_x       = x;
    w.key_y       = y;
    w.key_z       = z;
    return w;
  endfunction

  // Mostly well-formed segments: the two keyframes of the current segment are
  // written before any tick reads them, then ticks fall inside the segment.
  function automatic in_word_t next_word();
    int unsigned cnt;
    int unsigned seg;
    int unsigned r;
    logic [31:0] bt;
    logic [31:0] et;
    cnt = sb.eff_count();
    seg = sb.seg_index;
    r   = $urandom_range(99, 0);
    if (cnt < 2 || seg >= cnt - 1) begin
      if (r < 50) return tick_word($urandom);
      return key_word(SLOT_W'($urandom), $urandom, rand_coord(), rand_coord(), rand_coord());
    end
    if (!sb.written[seg]) begin
      if (sb.written[seg + 1]) begin
        et = sb.key_tab[seg + 1].key_time;
        bt = (et == 0) ? 32'h0 : et - span(et);
      end else begin
        bt = $urandom_range(32'h7FFF_FFFF, 0);
      end
      return key_word(6'(seg), bt, rand_coord(), rand_coord(), rand_coord());
    end
    bt = sb.key_tab[seg].key_time;
    if (!sb.written[seg + 1])
      return key_word(6'(seg + 1), fresh_end(bt), rand_coord(), rand_coord(), rand_coord());
    et = sb.key_tab[seg + 1].key_time;
    if (r < 10)
      return key_word(SLOT_W'($urandom), $urandom, rand_coord(), rand_coord(), rand_coord());
    if (r < 16)
      return key_word(6'(seg + 1), fresh_end(bt), rand_coord(), rand_coord(), rand_coord());
    if (r < 17)
      return key_word(6'(seg + 1), $urandom, rand_coord(), rand_coord(), rand_coord());
    if (r < 18) return key_word(6'(seg), $urandom, rand_coord(), rand_coord(), rand_coord());
    if (r < 22) return tick_word(et + $urandom_range(~et, 0));
    if (r < 27) return tick_word($urandom_range(bt, 0));
    if (et > bt && et - bt > 1) return tick_word(bt + $urandom_range(et - bt - 1, 1));
    return tick_word(bt);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_positions.size() != 0);
  endtask

  task automatic load_frame_count(input int value);
    cfg_data  <= value[CFG_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 68; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 68; end
      default:       begin idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  task automatic run_directed();
    send_word(tick_word($urandom));
    drain();
    load_frame_count(1);
    send_word(tick_word($urandom));
    drain();
    load_frame_count(64);
    send_word(key_word(6'd0, 32'h0001_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0));
    send_word(key_word(6'd1, 32'h0003_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1));
    // Before the start, at the start, half way, just short of the end, past it.
    send_word(tick_word(32'h0000_0000));
    send_word(tick_word(32'h0001_0000));
    send_word(tick_word(32'h0002_0000));
    send_word(tick_word(32'h0002_FFFF));
    send_word(tick_word(32'hFFFF_FFFF));
    // Equal keyframe times, then a time that goes backwards: both advance.
    send_word(key_word(6'd2, 32'h0003_0000, 32'sd12345, -32'sd777, 32'sh0001_0000));
    send_word(tick_word(32'h0000_0000));
    send_word(key_word(6'd3, 32'h0000_0000, -32'sd5, 32'sd5, 32'sh4000_0000));
    send_word(tick_word(32'h0000_0005));
    send_word(key_word(6'd4, 32'hFFFF_FFFF, 32'sd1, -32'sd1, 32'sh7FFF_FFFF));
    send_word(tick_word(32'h8000_0000));
    send_word(tick_word(32'hFFFF_FFFE));
    send_word(key_word(6'd63, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    // Count lowered under the current segment, then above the table size.
    drain();
    load_frame_count(3);
    send_word(tick_word(32'h0000_1000));
    drain();
    load_frame_count(127);
    send_word(tick_word(32'hFFFF_FFFF));
  endtask

  task automatic run_phase(input int p);
    int count;
    drain();
    count = phase_counts[p];
    if (count == COUNT_NEAR_END) count = (sb.seg_index + 2 > MAX_FRAMES) ? MAX_FRAMES
                                                                         : sb.seg_index + 2;
    load_frame_count(count);
    set_idling(idle_mode_e'(p % 4));
    // The receiver holds off long enough for the core to fill and stall its input.
    if (p == 2) hold_left = HOLD_OFF;
    for (int k = 0; k < PHASE_WORDS; k++) begin
      if (p == 1 && k == PHASE_WORDS / 2) drain();
      send_word(next_word());
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    set_idling(IDLE_NONE);
    run_directed();
    for (int p = 0; p < PHASES; p++) run_phase(p);
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Run covered %0d words: %0d keyframe writes, %0d ticks moved,",
             sb.n_inputs, sb.n_writes, sb.n_moved);
    $display("%0d advanced, %0d finished, %0d frame count writes, final segment %0d.",
             sb.n_advanced, sb.n_finished, cfg_writes, sb.seg_index);
    $display("%0d results checked, %0d mismatches.", sb.n_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_positions.size() == 0) begin
      $display("** keyframe_position_interpolator_core: PASSED **");
    end else begin
      $display("** keyframe_position_interpolator_core: FAILED **");
    end
    $finish;
  end

endmodule
